// ===== src/tcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsg_pkg: shared types and constants for the tilt cursor grid
// Transfer payload types, grid and calibration constants, and the
// constant-divisor average that turns calibration sums into baselines.
// ----------------------------------------------------------------------------
package tcsg_pkg;

    // Grid geometry. Field widths of the result transfer fix the position width.
    localparam int GRID_SIZE  = 16;
    localparam int POS_W      = 4;
    localparam int LED_W      = 8;

    // Calibration.
    localparam int CAL_SAMPLES = 20;
    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W       = SAMPLE_W + $clog2(CAL_SAMPLES);
    localparam int MAG_W       = SUM_W;
    localparam int CAL_SHIFT   = MAG_W + $clog2(CAL_SAMPLES);
    localparam int RECIP_W     = MAG_W + 1;
    localparam int PROD_W      = MAG_W + RECIP_W;

    // Rounded-up reciprocal of CAL_SAMPLES; exact for every magnitude below 2**MAG_W.
    localparam logic [RECIP_W-1:0] CAL_RECIP = RECIP_W'(
        ((longint'(1) << CAL_SHIFT) + longint'(CAL_SAMPLES) - longint'(1))
        / longint'(CAL_SAMPLES));

    // Configuration.
    localparam int THR_W = 15;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(10000);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] tilt_x;
        logic signed [SAMPLE_W-1:0] tilt_y;
    } tcsg_in_t;

    typedef struct packed {
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
        logic [LED_W-1:0] strip_index;
        logic             moved;
        logic             ready_res;
    } tcsg_out_t;

    typedef struct packed {
        logic                       calibrated;
        logic signed [SAMPLE_W-1:0] base_x;
        logic signed [SAMPLE_W-1:0] base_y;
    } cal_status_t;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [LED_W-1:0] led;
        logic             moved;
    } cursor_t;

    // Sum divided by CAL_SAMPLES, truncated toward zero.
    function automatic logic signed [SAMPLE_W-1:0] cal_average(
        input logic signed [SUM_W-1:0] sum
    );
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [SAMPLE_W-1:0] quot;
        neg  = sum[SUM_W-1];
        mag  = neg ? MAG_W'(-sum) : MAG_W'(sum);
        prod = PROD_W'(mag) * PROD_W'(CAL_RECIP);
        quot = prod[CAL_SHIFT +: SAMPLE_W];
        return neg ? -quot : quot;
    endfunction

endpackage

// ===== src/tilt_cursor_serpentine_grid.sv =====
// ----------------------------------------------------------------------------
// tilt_cursor_serpentine_grid: tilt-driven cursor on a serpentine LED grid
// Input register, calibration and cursor logic, result register.
// ----------------------------------------------------------------------------
// Each input transfer carries one two-axis tilt sample and produces exactly
// one result transfer. The block takes one sample per clock cycle while the
// result side does not stall. An accepted sample is held in the input
// register while the calibration and cursor logic settle, and its result is
// captured into the result register when the held sample moves on, which
// raises m_valid. The cursor position and the calibration sums are updated
// in the same cycle that the result is captured. While the result side
// stalls, one more sample is taken into the input register and then s_ready
// drops until the held result leaves. The first CAL_SAMPLES samples after
// reset only build the per-axis rest baselines; their results hold the
// cursor at the grid center with moved low, and ready_res goes high with
// the last of them. After that a deviation strictly beyond the move
// threshold steps the cursor one cell per axis, clamped at the grid edges.
// The threshold register should only be written while no transfer is in
// flight.
// ----------------------------------------------------------------------------
module tilt_cursor_serpentine_grid (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tcsg_pkg::tcsg_in_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tcsg_pkg::tcsg_out_t         m_data,
    input  logic                        cfg_wr_en,
    input  logic [tcsg_pkg::THR_W-1:0]  cfg_wr_data
);

    logic                          in_valid_reg;
    tcsg_pkg::tcsg_in_t            in_data_reg;
    logic                          out_valid_reg;
    tcsg_pkg::tcsg_out_t           out_data_reg, out_data_next;
    logic [tcsg_pkg::THR_W-1:0]    thr_reg;
    logic                          advance;
    tcsg_pkg::cal_status_t         cal_status;
    logic                          cal_ready;
    tcsg_pkg::cursor_t             cursor;

    // The held sample moves on whenever the result register is free or is
    // being emptied in this cycle; the input register refills in the same
    // cycle, so transfers stream back to back.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= tcsg_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Calibration state advances only when the held sample is consumed.
    tcsg_calib u_calib (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .sample    (in_data_reg),
        .status    (cal_status),
        .ready_now (cal_ready)
    );

    // The cursor sees the calibration state from before this sample, so the
    // last calibration sample itself never moves the cursor.
    tcsg_cursor u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .sample    (in_data_reg),
        .status    (cal_status),
        .threshold (thr_reg),
        .cursor    (cursor)
    );

    assign out_data_next.cursor_x    = cursor.col;
    assign out_data_next.cursor_y    = cursor.row;
    assign out_data_next.strip_index = cursor.led;
    assign out_data_next.moved       = cursor.moved;
    assign out_data_next.ready_res   = cal_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== src/tcsg_calib.sv =====
// ----------------------------------------------------------------------------
// tcsg_calib: rest baseline calibration
// Sums the first calibration samples per axis and latches their averages.
// ----------------------------------------------------------------------------
module tcsg_calib (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  tcsg_pkg::tcsg_in_t     sample,
    output tcsg_pkg::cal_status_t  status,
    output logic                   ready_now
);

    logic signed [tcsg_pkg::SUM_W-1:0]    sum_x_reg, sum_x_next;
    logic signed [tcsg_pkg::SUM_W-1:0]    sum_y_reg, sum_y_next;
    logic [tcsg_pkg::CNT_W-1:0]           cnt_reg;
    logic                                 calibrated_reg;
    logic signed [tcsg_pkg::SAMPLE_W-1:0] base_x_reg, base_y_reg;
    logic                                 last;

    assign sum_x_next = sum_x_reg + tcsg_pkg::SUM_W'(sample.tilt_x);
    assign sum_y_next = sum_y_reg + tcsg_pkg::SUM_W'(sample.tilt_y);
    assign last       = (cnt_reg == tcsg_pkg::CNT_W'(tcsg_pkg::CAL_SAMPLES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            cnt_reg        <= '0;
            calibrated_reg <= 1'b0;
            base_x_reg     <= '0;
            base_y_reg     <= '0;
        end else if (step && !calibrated_reg) begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            cnt_reg   <= cnt_reg + tcsg_pkg::CNT_W'(1);
            if (last) begin
                base_x_reg     <= tcsg_pkg::cal_average(sum_x_next);
                base_y_reg     <= tcsg_pkg::cal_average(sum_y_next);
                calibrated_reg <= 1'b1;
            end
        end
    end

    assign status.calibrated = calibrated_reg;
    assign status.base_x     = base_x_reg;
    assign status.base_y     = base_y_reg;
    assign ready_now         = calibrated_reg || last;

endmodule

// ===== src/tcsg_cursor.sv =====
// ----------------------------------------------------------------------------
// tcsg_cursor: cursor position and serpentine index
// Steps the cursor by threshold compares on each axis deviation, clamps it
// at the grid edges and maps the position to the strip index.
// ----------------------------------------------------------------------------
module tcsg_cursor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  tcsg_pkg::tcsg_in_t               sample,
    input  tcsg_pkg::cal_status_t            status,
    input  logic [tcsg_pkg::THR_W-1:0]       threshold,
    output tcsg_pkg::cursor_t                cursor
);

    localparam int DEV_W = tcsg_pkg::SAMPLE_W + 1;
    localparam logic [tcsg_pkg::POS_W-1:0] POS_MAX =
        tcsg_pkg::POS_W'(tcsg_pkg::GRID_SIZE - 1);
    localparam logic [tcsg_pkg::POS_W-1:0] POS_CENTER =
        tcsg_pkg::POS_W'((tcsg_pkg::GRID_SIZE - 1) / 2);

    logic [tcsg_pkg::POS_W-1:0] col_reg, col_next;
    logic [tcsg_pkg::POS_W-1:0] row_reg, row_next;
    logic signed [DEV_W-1:0]    dev_x, dev_y, thr_pos, thr_neg;
    logic                       moved;
    logic [tcsg_pkg::POS_W-1:0] led_col;

    // Full-width deviation, so a far-off sample cannot wrap around.
    assign dev_x   = DEV_W'(sample.tilt_x) - DEV_W'(status.base_x);
    assign dev_y   = DEV_W'(sample.tilt_y) - DEV_W'(status.base_y);
    assign thr_pos = DEV_W'({1'b0, threshold});
    assign thr_neg = -thr_pos;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        moved    = 1'b0;
        if (status.calibrated) begin
            if (dev_x > thr_pos && col_reg < POS_MAX) begin
                col_next = col_reg + tcsg_pkg::POS_W'(1);
                moved    = 1'b1;
            end else if (dev_x < thr_neg && col_reg != '0) begin
                col_next = col_reg - tcsg_pkg::POS_W'(1);
                moved    = 1'b1;
            end
            // Y grows downward, so a negative tilt moves to the next row.
            if (dev_y < thr_neg && row_reg < POS_MAX) begin
                row_next = row_reg + tcsg_pkg::POS_W'(1);
                moved    = 1'b1;
            end else if (dev_y > thr_pos && row_reg != '0) begin
                row_next = row_reg - tcsg_pkg::POS_W'(1);
                moved    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= POS_CENTER;
            row_reg <= POS_CENTER;
        end else if (step) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Odd rows of the strip run right to left.
    assign led_col = row_next[0] ? (POS_MAX - col_next) : col_next;

    assign cursor.col   = col_next;
    assign cursor.row   = row_next;
    assign cursor.moved = moved;
    assign cursor.led   = tcsg_pkg::LED_W'(tcsg_pkg::LED_W'(row_next)
                          * tcsg_pkg::LED_W'(tcsg_pkg::GRID_SIZE))
                          + tcsg_pkg::LED_W'(led_col);

endmodule
